[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

[sv/lfac_pkg.sv]
`timescale 1ns / 1ps

package lfac_pkg;

    // Defaults for the top level parameters
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 64;

    // Fixed field widths
    localparam int CFG_W    = 7;
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 6;
    localparam int STAMP_W  = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Scan sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    // One request as captured at accept
    typedef struct packed {
        logic                cmd;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] length;
        logic [STAMP_W-1:0]  now;
    } t_req;

    // One result
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] found_handle;
        logic [HANDLE_W-1:0] found_length;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } t_res;

endpackage

[sv/lfac_ram.sv]
`timescale 1ns / 1ps

// Simple dual port RAM, one write and one registered read per cycle.
module lfac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lfac_scan.sv]
`timescale 1ns / 1ps

// Slot scan sequencer: walks the slots in use one per cycle through the
// slot memories, finds a key match or a fill target, then writes back on an insert or a hit.
module lfac_scan
    import lfac_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_req             i_req,
    input  logic [CFG_W-1:0] i_cfg_count,
    output logic             o_busy,
    output logic             o_done,
    output t_res             o_res
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENT_W = KEY_BITS + 2 * HANDLE_W;

    t_state              r_state, n_state;
    logic [CAPACITY-1:0] r_valid;
    t_req                r_req;
    logic [IW-1:0]       r_last;
    logic [IW-1:0]       r_addr;
    logic                r_issue_done;
    logic                r_chk_vld;
    logic [IW-1:0]       r_chk_idx;
    logic [STAMP_W-1:0]  r_best_age;
    logic [IW-1:0]       r_best_idx;
    logic [HANDLE_W-1:0] r_best_handle;
    logic                r_hit;
    logic                r_ev;
    logic [IW-1:0]       r_target;
    logic [HANDLE_W-1:0] r_fh;
    logic [HANDLE_W-1:0] r_fl;
    logic [HANDLE_W-1:0] r_evh;

    logic [IW-1:0]       last_idx;
    logic                rd_en;
    logic [ENT_W-1:0]    ent_rd;
    logic [STAMP_W-1:0]  stamp_rd;
    logic [ENT_W-1:0]    ent_wr;
    logic                ent_we;
    logic                stamp_we;
    logic [KEY_BITS-1:0] rd_key;
    logic [HANDLE_W-1:0] rd_handle;
    logic [HANDLE_W-1:0] rd_length;
    logic [STAMP_W-1:0]  age;
    logic                slot_vld;
    logic                key_match;
    logic                is_last;
    logic                take;
    logic [STAMP_W-1:0]  sel_age;
    logic [IW-1:0]       sel_idx;
    logic [HANDLE_W-1:0] sel_handle;
    logic                proc;
    logic                is_insert;

    // clamp the slot count to 1..CAPACITY, kept as last index
    always_comb begin
        if (i_cfg_count == '0) begin
            last_idx = '0;
        end else if (int'(i_cfg_count) >= CAPACITY) begin
            last_idx = IW'(CAPACITY - 1);
        end else begin
            last_idx = IW'(i_cfg_count - CFG_W'(1));
        end
    end

    // slot memories: key/handle/length, and the age stamp
    assign rd_en     = (r_state == ST_SCAN) && !r_issue_done;
    assign is_insert = (r_req.cmd == CMD_INSERT);
    assign ent_we    = (r_state == ST_FINISH) && is_insert;
    assign stamp_we  = (r_state == ST_FINISH) && (is_insert || r_hit);
    assign ent_wr    = {r_req.key[KEY_BITS-1:0], r_req.handle, r_req.length};

    lfac_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_target),
        .i_wdata (ent_wr),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (ent_rd)
    );

    lfac_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (r_target),
        .i_wdata (r_req.now),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (stamp_rd)
    );

    // check stage on the slot that came back from memory
    assign rd_key    = ent_rd[ENT_W-1 -: KEY_BITS];
    assign rd_handle = ent_rd[2*HANDLE_W-1 -: HANDLE_W];
    assign rd_length = ent_rd[HANDLE_W-1:0];
    assign age       = r_req.now - stamp_rd;
    assign slot_vld  = r_valid[r_chk_idx];
    assign key_match = slot_vld && (rd_key == r_req.key[KEY_BITS-1:0]);
    assign is_last   = (r_chk_idx == r_last);
    assign proc      = (r_state == ST_SCAN) && r_chk_vld;

    // oldest entry so far, lowest index wins ties
    assign take       = (r_chk_idx == '0) || (age > r_best_age);
    assign sel_age    = take ? age : r_best_age;
    assign sel_idx    = take ? r_chk_idx : r_best_idx;
    assign sel_handle = take ? rd_handle : r_best_handle;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (proc) begin
                    if (is_insert) begin
                        if (!slot_vld || is_last) begin
                            n_state = ST_FINISH;
                        end
                    end else if (key_match || is_last) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (ent_we) begin
                r_valid[r_target] <= 1'b1;
            end
        end
    end

    // address issue and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_req        <= i_req;
            r_last       <= last_idx;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_ev         <= 1'b0;
            r_target     <= '0;
        end else if (r_state == ST_SCAN) begin
            r_chk_vld <= rd_en;
            r_chk_idx <= r_addr;
            if (rd_en) begin
                if (r_addr == r_last) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + IW'(1);
                end
            end
            if (proc) begin
                r_best_age    <= sel_age;
                r_best_idx    <= sel_idx;
                r_best_handle <= sel_handle;
                if (is_insert) begin
                    if (!slot_vld) begin
                        r_target <= r_chk_idx;
                    end else if (is_last) begin
                        r_target <= sel_idx;
                        r_ev     <= 1'b1;
                        r_evh    <= sel_handle;
                    end
                end else if (key_match) begin
                    r_hit    <= 1'b1;
                    r_target <= r_chk_idx;
                    r_fh     <= rd_handle;
                    r_fl     <= rd_length;
                end
            end
        end
    end

    // result, valid during the write-back cycle
    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_FINISH);

    always_comb begin
        o_res                = '0;
        o_res.hit            = r_hit;
        o_res.evicted        = r_ev;
        if (r_hit || is_insert) begin
            o_res.slot = SLOT_W'(r_target);
        end
        if (r_hit) begin
            o_res.found_handle = r_fh;
            o_res.found_length = r_fl;
        end
        if (r_ev) begin
            o_res.evicted_handle = r_evh;
        end
    end

endmodule

[sv/lru_fully_associative_cache_unit.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake                  Payload
// request  in   start & !busy              i_cmd, i_key, i_content_handle, i_content_length
// result   out  o_done, 1-cycle strobe     o_hit, o_slot, o_found_*, o_evicted*
// config   in   i_cfg_valid & o_cfg_ready  i_cfg_data (entries_in_use)
//
// Slots 0..k are read one per cycle from the slot memories, k being the matched
// or first empty slot, else the last slot in use (the count in use is clamped
// to 1..CAPACITY); the strobe follows the write-back state through an output
// register. Busy drops with the strobe; no new request is accepted while busy.
// Synchronous active-low reset empties the cache; memories need no clearing.
// Results cannot be stalled.
module lru_fully_associative_cache_unit
    import lfac_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [HANDLE_W-1:0] i_content_handle,
    input  logic [HANDLE_W-1:0] i_content_length,
    // result
    output logic                o_done,
    output logic                o_hit,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [HANDLE_W-1:0] o_found_handle,
    output logic [HANDLE_W-1:0] o_found_length,
    output logic                o_evicted,
    output logic [HANDLE_W-1:0] o_evicted_handle,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

`include "assert_macros.svh"

    logic [CFG_W-1:0]   r_entries;
    logic [STAMP_W-1:0] r_counter;
    logic               r_done;
    t_res               r_res;

    logic               accept;
    logic               scan_busy;
    logic               scan_done;
    t_req               req;
    t_res               scan_res;

    assign accept      = start && !scan_busy;
    assign o_cfg_ready = 1'b1;

    // request as seen by the scan, stamped with the current count
    always_comb begin
        req        = '0;
        req.cmd    = i_cmd;
        req.key    = i_key;
        req.handle = i_content_handle;
        req.length = i_content_length;
        req.now    = r_counter;
    end

    // config register and stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= CFG_RESET;
            r_counter <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_entries <= i_cfg_data;
            end
            if (accept) begin
                r_counter <= r_counter + STAMP_W'(1);
            end
        end
    end

    lfac_scan #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_req       (req),
        .i_cfg_count (r_entries),
        .o_busy      (scan_busy),
        .o_done      (scan_done),
        .o_res       (scan_res)
    );

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= scan_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_done) begin
            r_res <= scan_res;
        end
    end

    assign busy             = scan_busy;
    assign o_done           = r_done;
    assign o_hit            = r_res.hit;
    assign o_slot           = r_res.slot;
    assign o_found_handle   = r_res.found_handle;
    assign o_found_length   = r_res.found_length;
    assign o_evicted        = r_res.evicted;
    assign o_evicted_handle = r_res.evicted_handle;

    // checks
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, accept |=> busy)
    `ASSERT_CLK(a_done_single, i_clk, i_rst_n, o_done |=> !o_done)
    `ASSERT_CLK(a_done_from_busy, i_clk, i_rst_n, o_done |-> $past(busy))
    `ASSERT_NEVER(a_hit_and_evict, i_clk, i_rst_n, o_done && o_hit && o_evicted)

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb
    import lfac_pkg::*;
();

    // Directed table rows are either a request or a register write
    typedef enum logic {
        ROW_REQUEST,
        ROW_CONFIG
    } t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic                cmd;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] length;
        bit                  typed;   // answer below is used instead of the predictor
        t_res                answer;
        logic [CFG_W-1:0]    span;
    } t_stim_row;

    localparam t_res             RES_MISS = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_cmd;
    logic [KEY_W-1:0]    i_key;
    logic [HANDLE_W-1:0] i_content_handle;
    logic [HANDLE_W-1:0] i_content_length;
    logic                o_done;
    logic                o_hit;
    logic [SLOT_W-1:0]   o_slot;
    logic [HANDLE_W-1:0] o_found_handle;
    logic [HANDLE_W-1:0] o_found_length;
    logic                o_evicted;
    logic [HANDLE_W-1:0] o_evicted_handle;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data;

    // Shadow copy of the cache contents
    logic                slot_live   [CAPACITY_DEF];
    logic [KEY_W-1:0]    slot_key    [CAPACITY_DEF];
    logic [HANDLE_W-1:0] slot_handle [CAPACITY_DEF];
    logic [HANDLE_W-1:0] slot_length [CAPACITY_DEF];
    logic [STAMP_W-1:0]  slot_stamp  [CAPACITY_DEF];
    logic [STAMP_W-1:0]  request_clock;
    logic [CFG_W-1:0]    span_setting;

    t_res              answers_due[$];
    t_stim_row         directed_rows[$];
    logic [KEY_W-1:0]  key_pool[128];
    int                mismatch_count;

    lru_fully_associative_cache_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_key            (i_key),
        .i_content_handle (i_content_handle),
        .i_content_length (i_content_length),
        .o_done           (o_done),
        .o_hit            (o_hit),
        .o_slot           (o_slot),
        .o_found_handle   (o_found_handle),
        .o_found_length   (o_found_length),
        .o_evicted        (o_evicted),
        .o_evicted_handle (o_evicted_handle),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Slots actually scanned: 0 counts as 1, anything above capacity as capacity
    function automatic int active_slots();
        int n;
        n = int'(span_setting);
        if (n < 1) n = 1;
        if (n > CAPACITY_DEF) n = CAPACITY_DEF;
        return n;
    endfunction

    // Works out the answer to one request and updates the shadow cache
    function automatic t_res predict_cache_access(input logic                cmd,
                                                  input logic [KEY_W-1:0]    key,
                                                  input logic [HANDLE_W-1:0] handle,
                                                  input logic [HANDLE_W-1:0] length);
        int                 n;
        int                 target;
        bit                 have_empty;
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] age;
        logic [STAMP_W-1:0] oldest;
        t_res               res;
        n             = active_slots();
        now           = request_clock;
        request_clock = now + STAMP_W'(1);
        res           = '0;
        if (cmd == CMD_LOOKUP) begin
            // first matching valid slot wins
            for (int idx = 0; idx < n; idx++) begin
                if (slot_live[idx] && slot_key[idx] == key) begin
                    slot_stamp[idx]  = now;
                    res.hit          = 1'b1;
                    res.slot         = SLOT_W'(idx);
                    res.found_handle = slot_handle[idx];
                    res.found_length = slot_length[idx];
                    break;
                end
            end
        end else begin
            target     = 0;
            have_empty = 1'b0;
            for (int idx = 0; idx < n; idx++) begin
                if (!slot_live[idx]) begin
                    target     = idx;
                    have_empty = 1'b1;
                    break;
                end
            end
            // all full: replace greatest age, lowest index on a tie
            if (!have_empty) begin
                oldest = '0;
                for (int idx = 0; idx < n; idx++) begin
                    age = now - slot_stamp[idx];
                    if (idx == 0 || age > oldest) begin
                        oldest = age;
                        target = idx;
                    end
                end
                res.evicted        = 1'b1;
                res.evicted_handle = slot_handle[target];
            end
            slot_live[target]   = 1'b1;
            slot_key[target]    = key;
            slot_handle[target] = handle;
            slot_length[target] = length;
            slot_stamp[target]  = now;
            res.slot            = SLOT_W'(target);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Result monitor: every strobe must match the oldest pending answer
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result strobe with no request pending");
            end else begin
                want = answers_due.pop_front();
                check_field("hit", 64'(o_hit), 64'(want.hit));
                check_field("slot", 64'(o_slot), 64'(want.slot));
                check_field("found_handle", 64'(o_found_handle), 64'(want.found_handle));
                check_field("found_length", 64'(o_found_length), 64'(want.found_length));
                check_field("evicted", 64'(o_evicted), 64'(want.evicted));
                check_field("evicted_handle", 64'(o_evicted_handle),
                            64'(want.evicted_handle));
            end
        end
    end

    // Drive one request and hold it until the block takes it
    task automatic send_request(input logic                cmd,
                                input logic [KEY_W-1:0]    key,
                                input logic [HANDLE_W-1:0] handle,
                                input logic [HANDLE_W-1:0] length,
                                input bit                  typed,
                                input t_res                answer);
        t_res predicted;
        @(negedge i_clk);
        start            <= 1'b1;
        i_cmd            <= cmd;
        i_key            <= key;
        i_content_handle <= handle;
        i_content_length <= length;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = predict_cache_access(cmd, key, handle, length);
        answers_due.push_back(typed ? answer : predicted);
    endtask

    // Sender gaps: mostly short, sometimes long enough to land late in a scan
    task automatic sender_pause(input int pct);
        int gap;
        gap = 0;
        if (pct > 0 && $urandom_range(0, 15) == 0)
            gap = $urandom_range(1, 70);
        else
            while ($urandom_range(0, 99) < pct) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending and wait until every pending transaction has come back
    task automatic settle_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_span(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        span_setting = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase at a given register value and sender idle rate
    task automatic run_phase(input logic [CFG_W-1:0] span, input int count,
                             input int pct);
        int                  spread;
        logic                cmd;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] length;
        settle_idle();
        write_span(span);
        // keep the key pool a bit larger than the cache so hits and misses mix
        spread = active_slots() * 3 / 2 + 2;
        if (spread > 128) spread = 128;
        for (int n = 0; n < count; n++) begin
            cmd    = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
            key    = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, spread - 1)]
                                                  : {$urandom, $urandom};
            handle = $urandom;
            length = $urandom;
            case ($urandom_range(0, 15))
                0: handle = '0;
                1: handle = '1;
                2: length = '0;
                3: length = '1;
                default: ;
            endcase
            if (n == count / 2) settle_idle();
            sender_pause(pct);
            send_request(cmd, key, handle, length, 1'b0, RES_MISS);
        end
    endtask

    initial begin
        mismatch_count   = 0;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_cmd            = CMD_LOOKUP;
        i_key            = '0;
        i_content_handle = '0;
        i_content_length = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = CFG_RESET;
        request_clock    = '0;
        span_setting     = CFG_RESET;
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = KEY_ONES;

        // Directed: extremes, duplicates, eviction and out-of-range register values
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, '0, '0, '0, 1'b1, RES_MISS, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, KEY_ONES, '1, '1, 1'b1,
                                  RES_MISS, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_INSERT, '0, '1, '0, 1'b1,
            {1'b0, 6'd0, 32'd0, 32'd0, 1'b0, 32'd0}, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_INSERT, KEY_ONES, '0, '1, 1'b1,
            {1'b0, 6'd1, 32'd0, 32'd0, 1'b0, 32'd0}, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, '0, '0, '0, 1'b1,
            {1'b1, 6'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0}, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, KEY_ONES, '0, '0, 1'b1,
            {1'b1, 6'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0}, '0});
        // duplicate key goes to a fresh slot, lookup still answers the lowest
        directed_rows.push_back('{ROW_REQUEST, CMD_INSERT, '0, 32'h1234, 32'd7, 1'b1,
            {1'b0, 6'd2, 32'd0, 32'd0, 1'b0, 32'd0}, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, '0, '0, '0, 1'b1,
            {1'b1, 6'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0}, '0});
        // two slots in use: next insert replaces the older one
        directed_rows.push_back('{ROW_CONFIG, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, 7'd2});
        directed_rows.push_back('{ROW_REQUEST, CMD_INSERT, 64'hA5A5_A5A5_A5A5_A5A5,
                                  32'hAAAA_5555, 32'h10, 1'b0, RES_MISS, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, KEY_ONES, '0, '0, 1'b0,
                                  RES_MISS, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, '0});
        // zero counts as one slot
        directed_rows.push_back('{ROW_CONFIG, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, 7'd0});
        directed_rows.push_back('{ROW_REQUEST, CMD_INSERT, 64'h5555_5555_5555_5555,
                                  32'h5555_AAAA, '1, 1'b0, RES_MISS, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, '0});
        // maximum register value: hidden slots come back
        directed_rows.push_back('{ROW_CONFIG, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, 7'd127});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, 64'hA5A5_A5A5_A5A5_A5A5, '0, '0,
                                  1'b0, RES_MISS, '0});
        directed_rows.push_back('{ROW_CONFIG, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, 7'd65});
        directed_rows.push_back('{ROW_REQUEST, CMD_INSERT, 64'h0123_4567_89AB_CDEF,
                                  32'h0BAD_F00D, 32'd1, 1'b0, RES_MISS, '0});
        directed_rows.push_back('{ROW_CONFIG, CMD_LOOKUP, '0, '0, '0, 1'b0, RES_MISS, 7'd1});
        directed_rows.push_back('{ROW_REQUEST, CMD_INSERT, 64'h8000_0000_0000_0001,
                                  32'h8000_0001, 32'h7FFF_FFFF, 1'b0, RES_MISS, '0});
        directed_rows.push_back('{ROW_REQUEST, CMD_LOOKUP, 64'h8000_0000_0000_0001, '0, '0,
                                  1'b0, RES_MISS, '0});

        // synchronous reset, released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CONFIG) begin
                settle_idle();
                write_span(directed_rows[r].span);
            end else begin
                send_request(directed_rows[r].cmd, directed_rows[r].key,
                             directed_rows[r].handle, directed_rows[r].length,
                             directed_rows[r].typed, directed_rows[r].answer);
            end
        end

        // Random phases over register values and sender idle rates
        run_phase(7'd64, 250, 0);
        run_phase(7'd1, 150, 63);
        run_phase(7'd8, 200, 27);
        run_phase(7'd3, 150, 0);
        run_phase(7'd127, 250, 63);
        run_phase(7'd0, 100, 27);
        run_phase(7'd16, 200, 0);
        run_phase(7'd65, 150, 27);
        run_phase(7'd64, 150, 63);

        settle_idle();
        repeat (70) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[lru_fully_associative_cache_unit.f]
+incdir+sv
sv/lfac_pkg.sv
sv/lfac_ram.sv
sv/lfac_scan.sv
sv/lru_fully_associative_cache_unit.sv
sim/tb.sv
